// File: rtl/core/mpve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpve_pkg
// Shared constants, types and helper functions of the meter packet validator
// and field extractor.
// ----------------------------------------------------------------------------
package mpve_pkg;

    // Packet layout
    localparam int BLOCK_BYTES  = 64;
    localparam int PACKET_BYTES = 3 * BLOCK_BYTES;
    localparam int CRC_SPAN     = BLOCK_BYTES - 4;
    localparam int OFF_W        = $clog2(BLOCK_BYTES);
    localparam int POS_W        = $clog2(PACKET_BYTES + 1);
    localparam int BLK_W        = POS_W - OFF_W;

    // Result fields
    localparam int FIELD_COUNT = 14;
    localparam int TEMP_FIELD  = 11;
    localparam int FID_W       = 4;
    localparam int WORD_W      = 32;
    localparam int VALUE_W     = 33;
    localparam int STATUS_W    = 2;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // Job queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Block header text
    localparam logic [7:0] MAGIC_0 = 8'h70; // 'p'
    localparam logic [7:0] MAGIC_1 = 8'h61; // 'a'
    localparam logic [7:0] MAGIC_2 = 8'h63; // 'c'
    localparam logic [7:0] MAGIC_3 = 8'h31; // '1', plus block number

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_MAGIC = 2'd2,
        ST_CRC   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SLOT_NONE  = 2'd0,
        SLOT_FIELD = 2'd1,
        SLOT_TSIGN = 2'd2
    } slot_kind_t;

    typedef struct packed {
        slot_kind_t       kind;
        logic [FID_W-1:0] idx;
    } slot_t;

    // One finished packet handed from front to back
    typedef struct packed {
        status_t                              status;
        logic                                 temp_neg;
        logic [FIELD_COUNT-1:0][WORD_W-1:0]   fields;
    } job_t;

    // Bytewise CRC-16/MODBUS update
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Expected header byte at offset off of block blk
    function automatic logic [7:0] magic_byte(input logic [1:0] off, input logic [BLK_W-1:0] blk);
        logic [7:0] m;
        case (off)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_3 + 8'(blk);
        endcase
        return m;
    endfunction

    // Destination of the word that starts at packet position start
    function automatic slot_t field_slot(input logic [POS_W-1:0] start);
        slot_t s;
        s.kind = SLOT_FIELD;
        s.idx  = '0;
        case (start)
            POS_W'(4):                s.idx = FID_W'(0);
            POS_W'(8):                s.idx = FID_W'(1);
            POS_W'(12):               s.idx = FID_W'(2);
            POS_W'(48):               s.idx = FID_W'(3);
            POS_W'(52):               s.idx = FID_W'(4);
            POS_W'(56):               s.idx = FID_W'(5);
            POS_W'(BLOCK_BYTES + 4):  s.idx = FID_W'(6);
            POS_W'(BLOCK_BYTES + 8):  s.idx = FID_W'(7);
            POS_W'(BLOCK_BYTES + 12): s.idx = FID_W'(8);
            POS_W'(BLOCK_BYTES + 16): s.idx = FID_W'(9);
            POS_W'(BLOCK_BYTES + 20): s.idx = FID_W'(10);
            POS_W'(BLOCK_BYTES + 24): s.kind = SLOT_TSIGN;
            POS_W'(BLOCK_BYTES + 28): s.idx = FID_W'(11);
            POS_W'(BLOCK_BYTES + 32): s.idx = FID_W'(12);
            POS_W'(BLOCK_BYTES + 36): s.idx = FID_W'(13);
            default:                  s.kind = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/mpve_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpve_front
// Byte parser: tracks position, checks block headers and CRCs, captures the
// measurement words and posts one job per packet to the queue.
// ----------------------------------------------------------------------------
module mpve_front
    import mpve_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [7:0] data_byte
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 push_job
);

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [15:0]       crc_reg,  crc_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              tneg_reg, tneg_next;
    status_t           err_reg,  err_next;
    logic [FIELD_COUNT-1:0][WORD_W-1:0] field_reg;

    logic              accept;
    logic              in_pkt;
    logic [OFF_W-1:0]  off;
    logic [BLK_W-1:0]  blk;
    logic [7:0]        b;
    slot_t             slot;
    logic              field_we;
    logic [POS_W-1:0]  pos_taken;
    logic              tneg_taken;
    status_t           err_taken;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata[7:0];
    assign in_pkt   = pos_reg < POS_W'(PACKET_BYTES);
    assign off      = pos_reg[OFF_W-1:0];
    assign blk      = pos_reg[POS_W-1:OFF_W];
    assign slot     = field_slot(pos_reg - POS_W'(3));

    // Process one in-packet byte
    always_comb begin
        pos_taken  = pos_reg;
        crc_next   = crc_reg;
        word_next  = word_reg;
        tneg_taken = tneg_reg;
        err_taken  = err_reg;
        field_we   = 1'b0;
        if (accept && in_pkt) begin
            pos_taken = pos_reg + POS_W'(1);
            word_next = {b, word_reg[WORD_W-1:8]};
            if (off < OFF_W'(4) && b != magic_byte(off[1:0], blk) && err_reg == ST_OK) begin
                err_taken = ST_MAGIC;
            end
            if (off < OFF_W'(CRC_SPAN)) begin
                crc_next = crc16_byte(crc_reg, b);
            end
            if (off[1:0] == 2'd3) begin
                if (slot.kind == SLOT_FIELD) begin
                    field_we = 1'b1;
                end else if (slot.kind == SLOT_TSIGN) begin
                    tneg_taken = (word_next == WORD_W'(1));
                end
            end
            if (off == OFF_W'(BLOCK_BYTES - 1)) begin
                if (word_next[15:0] != crc_reg && err_reg == ST_OK) begin
                    err_taken = ST_CRC;
                end
                crc_next = CRC_INIT;
            end
        end
    end

    // Close the packet on the flagged byte
    always_comb begin
        push              = accept && s_tlast;
        push_job.status   = (pos_taken < POS_W'(PACKET_BYTES)) ? ST_SHORT : err_taken;
        push_job.temp_neg = tneg_taken;
        push_job.fields   = field_reg;
        pos_next          = pos_taken;
        tneg_next         = tneg_taken;
        err_next          = err_taken;
        if (push) begin
            pos_next  = '0;
            tneg_next = 1'b0;
            err_next  = ST_OK;
        end
    end

    // Per-packet control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= CRC_INIT;
            word_reg <= '0;
            tneg_reg <= 1'b0;
            err_reg  <= ST_OK;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= (push) ? CRC_INIT : crc_next;
            word_reg <= (push) ? '0 : word_next;
            tneg_reg <= tneg_next;
            err_reg  <= err_next;
        end
    end

    // Capture measurement words
    always_ff @(posedge aclk) begin
        if (field_we) begin
            field_reg[slot.idx] <= word_next;
        end
    end

endmodule

// File: rtl/core/mpve_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpve_queue
// Short job queue between the byte parser and the result emitter.
// ----------------------------------------------------------------------------
module mpve_queue
    import mpve_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty,
    output logic full
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_job = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the posted job
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/mpve_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpve_back
// Result emitter: walks the head job and drives one result per cycle, while the
// output is not stalled, into the output register, then releases the job.
// ----------------------------------------------------------------------------
module mpve_back
    import mpve_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  job_t                 head_job,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [1:0] status, [5:2] field_id, [38:6] value
    output logic                 m_tlast
);

    logic [FID_W-1:0]   idx_reg, idx_next;
    logic               valid_reg, valid_next;
    status_t            status_reg;
    logic [FID_W-1:0]   fid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;

    logic               load;
    status_t            res_status;
    logic [FID_W-1:0]   res_fid;
    logic [VALUE_W-1:0] res_value;
    logic               res_last;
    logic [WORD_W-1:0]  word;

    assign load = !empty && (!valid_reg || m_tready);
    assign word = head_job.fields[idx_reg];

    // Form the next result from the head job
    always_comb begin
        if (head_job.status != ST_OK) begin
            res_status = head_job.status;
            res_fid    = '0;
            res_value  = '0;
            res_last   = 1'b1;
        end else begin
            res_status = ST_OK;
            res_fid    = idx_reg;
            res_value  = {1'b0, word};
            if (idx_reg == FID_W'(TEMP_FIELD) && head_job.temp_neg) begin
                res_value = VALUE_W'(0) - {1'b0, word};
            end
            res_last   = idx_reg == FID_W'(FIELD_COUNT - 1);
        end
    end

    // Step the index, release the job after its last result
    always_comb begin
        pop        = load && res_last;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = res_last ? '0 : idx_reg + FID_W'(1);
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= res_status;
            fid_reg    <= res_fid;
            value_reg  <= res_value;
            last_reg   <= res_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, value_reg, fid_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule

// File: rtl/core/meter_packet_validate_extract_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_packet_validate_extract_unit
// Validates a decrypted 192-byte meter packet (block headers, CRC-16/MODBUS
// per block) and emits either one error result or its 14 measurement words.
//
//  Channel | Dir | tdata fields (low bit up)                | tlast
//  s_      | in  | data_byte[7:0]                           | end_of_packet
//  m_      | out | status[1:0] field_id[5:2] value[38:6]    | last_result
//
// One input byte is taken every cycle; the parser updates CRC, header check
// and word capture in that cycle. On the flagged byte the packet is posted to
// a two-entry job queue. The emitter sends one result per cycle while the
// output is not stalled: 14 results for a good packet, one for an error.
// Input stalls only while both queue entries hold packets; output stalls
// hold the output register in place. Reset (synchronous, aresetn low)
// clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module meter_packet_validate_extract_unit
    import mpve_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [7:0] data_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [1:0] status, [5:2] field_id, [38:6] value
    output logic                 m_tlast
);

    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    job_t push_job;
    job_t head_job;

    mpve_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    mpve_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    mpve_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
